[sv/lpi_pkg.sv]
// ----------------------------------------------------------------------------
// lpi_pkg: shared types and widths for the line pair intersection block
// Word structs for both channels, relation codes and datapath widths.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int CRD_W   = 20;           // input field width
  localparam int COORD_BITS_DEF = 20;    // default coordinate width
  localparam int AB_W    = CRD_W + 1;    // line coefficients a, b
  localparam int PX_W    = AB_W + CRD_W; // a*x, b*y
  localparam int DP_W    = 2 * AB_W;     // a*b products
  localparam int CC_W    = PX_W + 2;     // coefficient c
  localparam int DT_W    = DP_W + 1;     // determinant
  localparam int LO_W    = 22;           // low slice of c
  localparam int HI_W    = CC_W - LO_W;  // high slice of c
  localparam int LP_W    = AB_W + LO_W + 1;
  localparam int HP_W    = AB_W + HI_W;
  localparam int XW      = 64;           // cross terms and results
  localparam int MAG_W   = 62;           // cross term magnitude
  localparam int DEN_W   = DT_W;         // divisor magnitude
  localparam int NUM_W   = MAG_W + 7;    // 100 * magnitude
  localparam int DIV_LAT = NUM_W + 3;    // divider latency

  localparam logic [1:0] REL_PARALLEL   = 2'd0;
  localparam logic [1:0] REL_SINGLE     = 2'd1;
  localparam logic [1:0] REL_COINCIDENT = 2'd2;

  typedef struct packed {
    logic signed [CRD_W-1:0] first_start_x;
    logic signed [CRD_W-1:0] first_start_y;
    logic signed [CRD_W-1:0] first_end_x;
    logic signed [CRD_W-1:0] first_end_y;
    logic signed [CRD_W-1:0] second_start_x;
    logic signed [CRD_W-1:0] second_start_y;
    logic signed [CRD_W-1:0] second_end_x;
    logic signed [CRD_W-1:0] second_end_y;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           relation;
    logic signed [XW-1:0] cross_x_hundredths;
    logic signed [XW-1:0] cross_y_hundredths;
  } out_word_t;

endpackage

[sv/lpi_div.sv]
// ----------------------------------------------------------------------------
// lpi_div: pipelined rounding divider
// One quotient bit per stage, then round half up on the magnitude,
// saturate to signed 64 bits and apply the sign.
// ----------------------------------------------------------------------------
module lpi_div import lpi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  input  logic                 neg,
  output logic                 out_valid,
  output logic signed [XW-1:0] quo
);

  logic             v   [0:NUM_W];
  logic [DEN_W-1:0] rem [0:NUM_W];
  logic [NUM_W-1:0] nsh [0:NUM_W];
  logic [NUM_W-1:0] qa  [0:NUM_W];
  logic [DEN_W-1:0] da  [0:NUM_W];
  logic             ng  [0:NUM_W];

  logic [DEN_W:0] trial [0:NUM_W-1];
  logic           ge    [0:NUM_W-1];
  logic [DEN_W:0] diff  [0:NUM_W-1];

  logic             rv;
  logic [XW-1:0]    rm;
  logic             rneg;

  logic             rnd;
  logic [NUM_W:0]   qp;
  logic [XW-1:0]    limit;

  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      trial[i] = {rem[i], nsh[i][NUM_W-1]};
      ge[i]    = trial[i] >= {1'b0, da[i]};
      diff[i]  = trial[i] - {1'b0, da[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NUM_W; i++) begin
        v[i] <= 1'b0;
      end
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int i = 0; i < NUM_W; i++) begin
        v[i+1] <= v[i];
      end
      rv        <= v[NUM_W];
      out_valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= '0;
    nsh[0] <= num;
    qa[0]  <= '0;
    da[0]  <= den;
    ng[0]  <= neg;
    for (int i = 0; i < NUM_W; i++) begin
      rem[i+1] <= ge[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
      nsh[i+1] <= nsh[i] << 1;
      qa[i+1]  <= {qa[i][NUM_W-2:0], ge[i]};
      da[i+1]  <= da[i];
      ng[i+1]  <= ng[i];
    end
  end

  always_comb begin
    rnd   = {rem[NUM_W], 1'b0} >= {1'b0, da[NUM_W]};
    qp    = {1'b0, qa[NUM_W]} + (NUM_W+1)'(rnd);
    limit = ng[NUM_W] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    rneg <= ng[NUM_W];
    if (qp > (NUM_W+1)'(limit)) begin
      rm <= limit;
    end else begin
      rm <= qp[XW-1:0];
    end
    quo <= rneg ? $signed(-rm) : $signed(rm);
  end

endmodule

[sv/line_pair_intersection.sv]
// ----------------------------------------------------------------------------
// line_pair_intersection: intersection of two lines given by point pairs
// Exact integer coefficients and determinant, then a rounded quotient in
// hundredths for each coordinate of a single crossing point.
// ----------------------------------------------------------------------------
// channel   dir   handshake          word
// item      in    start & !busy      in_word_t
// result    out   done (1 cycle)     out_word_t
//
// Fully pipelined: a new word may be taken every cycle; busy stays low.
// The divider resolves one quotient bit per stage over NUM_W stages.
// Reset clears the valid bits only; words in flight are dropped.
// The receiver cannot stall, so results leave on done without backpressure.
// ----------------------------------------------------------------------------
module line_pair_intersection import lpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item,
  output logic      done,
  output out_word_t result
);

  localparam int SH = CRD_W - COORD_BITS;

  function automatic logic signed [CRD_W-1:0] crd(input logic signed [CRD_W-1:0] raw);
    logic signed [CRD_W-1:0] t;
    t = raw <<< SH;
    return t >>> SH;
  endfunction

  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;

  logic signed [CRD_W-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic signed [AB_W-1:0]  a1, b1, a2, b2;
  logic signed [CRD_W-1:0] bx2, by2, dx2, dy2;
  logic signed [PX_W-1:0]  pa1, pb1, pa2, pb2;
  logic signed [DP_W-1:0]  da, db;
  logic signed [AB_W-1:0]  a1_3, b1_3, a2_3, b2_3;
  logic signed [CC_W-1:0]  c1, c2;
  logic signed [DT_W-1:0]  det4, det5, det6, det7;
  logic signed [AB_W-1:0]  a1_4, b1_4, a2_4, b2_4;
  logic signed [LP_W-1:0]  a1c2_lo, a2c1_lo, b1c2_lo, b2c1_lo;
  logic signed [HP_W-1:0]  a1c2_hi, a2c1_hi, b1c2_hi, b2c1_hi;
  logic signed [XW-1:0]    a1c2, a2c1, b1c2, b2c1;
  logic signed [XW-1:0]    cra, crb;
  logic [1:0]              rel8, rel9;
  logic [MAG_W-1:0]        nx8, ny8;
  logic [DEN_W-1:0]        den8, den9;
  logic                    negx8, negy8, negx9, negy9;
  logic [NUM_W-1:0]        numx9, numy9;

  logic [1:0]              rel_d [0:DIV_LAT-1];
  logic                    xv, yv;
  logic signed [XW-1:0]    xq, yq;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
      done <= xv;
    end
  end

  always_ff @(posedge clk) begin
    ax <= crd(item.first_start_x);
    ay <= crd(item.first_start_y);
    bx <= crd(item.first_end_x);
    by <= crd(item.first_end_y);
    cx <= crd(item.second_start_x);
    cy <= crd(item.second_start_y);
    dx <= crd(item.second_end_x);
    dy <= crd(item.second_end_y);

    a1 <= AB_W'(by) - AB_W'(ay);
    b1 <= AB_W'(ax) - AB_W'(bx);
    a2 <= AB_W'(dy) - AB_W'(cy);
    b2 <= AB_W'(cx) - AB_W'(dx);
    bx2 <= bx; by2 <= by; dx2 <= dx; dy2 <= dy;

    pa1 <= a1 * bx2;
    pb1 <= b1 * by2;
    pa2 <= a2 * dx2;
    pb2 <= b2 * dy2;
    da  <= a1 * b2;
    db  <= a2 * b1;
    a1_3 <= a1; b1_3 <= b1; a2_3 <= a2; b2_3 <= b2;

    c1   <= -(CC_W'(pa1) + CC_W'(pb1));
    c2   <= -(CC_W'(pa2) + CC_W'(pb2));
    det4 <= DT_W'(da) - DT_W'(db);
    a1_4 <= a1_3; b1_4 <= b1_3; a2_4 <= a2_3; b2_4 <= b2_3;

    a1c2_lo <= a1_4 * $signed({1'b0, c2[LO_W-1:0]});
    a2c1_lo <= a2_4 * $signed({1'b0, c1[LO_W-1:0]});
    b1c2_lo <= b1_4 * $signed({1'b0, c2[LO_W-1:0]});
    b2c1_lo <= b2_4 * $signed({1'b0, c1[LO_W-1:0]});
    a1c2_hi <= a1_4 * $signed(c2[CC_W-1:LO_W]);
    a2c1_hi <= a2_4 * $signed(c1[CC_W-1:LO_W]);
    b1c2_hi <= b1_4 * $signed(c2[CC_W-1:LO_W]);
    b2c1_hi <= b2_4 * $signed(c1[CC_W-1:LO_W]);
    det5 <= det4;

    a1c2 <= (XW'(a1c2_hi) <<< LO_W) + XW'(a1c2_lo);
    a2c1 <= (XW'(a2c1_hi) <<< LO_W) + XW'(a2c1_lo);
    b1c2 <= (XW'(b1c2_hi) <<< LO_W) + XW'(b1c2_lo);
    b2c1 <= (XW'(b2c1_hi) <<< LO_W) + XW'(b2c1_lo);
    det6 <= det5;

    cra  <= a1c2 - a2c1;
    crb  <= b1c2 - b2c1;
    det7 <= det6;

    if (det7 != '0) begin
      rel8 <= REL_SINGLE;
    end else if (cra == '0 && crb == '0) begin
      rel8 <= REL_COINCIDENT;
    end else begin
      rel8 <= REL_PARALLEL;
    end
    nx8   <= crb[XW-1] ? MAG_W'(-crb) : MAG_W'(crb);
    ny8   <= cra[XW-1] ? MAG_W'(-cra) : MAG_W'(cra);
    negx8 <= crb[XW-1] != det7[DT_W-1];
    negy8 <= (cra != '0 && !cra[XW-1]) != det7[DT_W-1];
    den8  <= det7[DT_W-1] ? DEN_W'(-det7) : DEN_W'(det7);

    numx9 <= (NUM_W'(nx8) << 6) + (NUM_W'(nx8) << 5) + (NUM_W'(nx8) << 2);
    numy9 <= (NUM_W'(ny8) << 6) + (NUM_W'(ny8) << 5) + (NUM_W'(ny8) << 2);
    den9  <= den8;
    negx9 <= negx8;
    negy9 <= negy8;
    rel9  <= rel8;

    rel_d[0] <= rel9;
    for (int i = 1; i < DIV_LAT; i++) begin
      rel_d[i] <= rel_d[i-1];
    end

    result.relation <= rel_d[DIV_LAT-1];
    if (rel_d[DIV_LAT-1] == REL_SINGLE) begin
      result.cross_x_hundredths <= xq;
      result.cross_y_hundredths <= yq;
    end else begin
      result.cross_x_hundredths <= '0;
      result.cross_y_hundredths <= '0;
    end
  end

  lpi_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .num       (numx9),
    .den       (den9),
    .neg       (negx9),
    .out_valid (xv),
    .quo       (xq)
  );

  lpi_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .num       (numy9),
    .den       (den9),
    .neg       (negy9),
    .out_valid (yv),
    .quo       (yq)
  );

  a_busy_low: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  a_div_align: assert property (@(posedge clk) disable iff (rst) xv == yv)
    else $error("divider lanes out of step");

  a_rel_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.relation == REL_PARALLEL || result.relation == REL_SINGLE ||
              result.relation == REL_COINCIDENT))
    else $error("bad relation code");

  a_no_point: assert property (@(posedge clk) disable iff (rst)
    done && result.relation != REL_SINGLE |->
      result.cross_x_hundredths == '0 && result.cross_y_hundredths == '0)
    else $error("point reported without single crossing");

endmodule

[tb/tb_line_pair_intersection.sv]
// ----------------------------------------------------------------------------
// tb_line_pair_intersection: self-checking bench for line_pair_intersection
// Drives directed and random line pairs and predicts each result word in
// exact integer arithmetic. Results are checked in order by a scoreboard.
// ----------------------------------------------------------------------------
import lpi_pkg::*;

class lpi_scoreboard;
  out_word_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function logic signed [XW-1:0] hundredths(logic signed [127:0] num,
                                                  logic signed [127:0] den);
    logic neg;
    logic [127:0] n, d, q, r, q2, r2, m, lim;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    r = n % d;
    q2 = (100 * r) / d;
    r2 = (100 * r) % d;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (num == 0) return '0;
    m = 100 * q + q2 + ((2 * r2 >= d) ? 1 : 0);
    if (m > lim) m = lim;
    return neg ? -m[63:0] : m[63:0];
  endfunction

  static function logic signed [127:0] crd(logic signed [CRD_W-1:0] v);
    logic signed [127:0] t;
    t = v;
    return t;
  endfunction

  function void note_item(in_word_t w);
    logic signed [127:0] a1, b1, c1, a2, b2, c2, det, ca, cb;
    out_word_t e;
    a1 = crd(w.first_end_y) - crd(w.first_start_y);
    b1 = crd(w.first_start_x) - crd(w.first_end_x);
    c1 = -(a1 * crd(w.first_end_x) + b1 * crd(w.first_end_y));
    a2 = crd(w.second_end_y) - crd(w.second_start_y);
    b2 = crd(w.second_start_x) - crd(w.second_end_x);
    c2 = -(a2 * crd(w.second_end_x) + b2 * crd(w.second_end_y));
    det = a1 * b2 - a2 * b1;
    ca = a1 * c2 - a2 * c1;
    cb = b1 * c2 - b2 * c1;
    e = '0;
    if (det == 0) begin
      e.relation = (ca == 0 && cb == 0) ? REL_COINCIDENT : REL_PARALLEL;
    end else begin
      e.relation = REL_SINGLE;
      e.cross_x_hundredths = hundredths(cb, det);
      e.cross_y_hundredths = hundredths(-ca, det);
    end
    pending.push_back(e);
  endfunction

  function void check_result(out_word_t got);
    out_word_t e;
    if (pending.size() == 0) begin
      $error("result word with nothing pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.relation !== e.relation) begin
      $error("relation: expected %0d got %0d", e.relation, got.relation);
      errors++;
    end
    if (got.cross_x_hundredths !== e.cross_x_hundredths) begin
      $error("cross_x_hundredths: expected %0d got %0d",
             e.cross_x_hundredths, got.cross_x_hundredths);
      errors++;
    end
    if (got.cross_y_hundredths !== e.cross_y_hundredths) begin
      $error("cross_y_hundredths: expected %0d got %0d",
             e.cross_y_hundredths, got.cross_y_hundredths);
      errors++;
    end
  endfunction
endclass

module tb_line_pair_intersection;
  localparam int WATCHDOG = 5000;
  localparam int DRAIN = 120;
  localparam logic signed [CRD_W-1:0] CMAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] CMIN = {1'b1, {(CRD_W-1){1'b0}}};

  logic clk, rst, start, busy, done;
  in_word_t item;
  out_word_t result;
  lpi_scoreboard sb;
  int quiet;

  line_pair_intersection dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
    if (rst || done || (start && !busy)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("tb_line_pair_intersection NOT OK");
      $finish;
    end
  end

  function automatic logic signed [CRD_W-1:0] rnd_crd();
    case ($urandom_range(0, 5))
      0: return CMAX - CRD_W'($urandom_range(0, 3));
      1: return CMIN + CRD_W'($urandom_range(0, 3));
      2: return CRD_W'($urandom_range(0, 40) - 20);
      default: return CRD_W'($urandom);
    endcase
  endfunction

  // hold start until the word is taken; call at a falling edge
  task automatic send(in_word_t w, bit gaps);
    while (gaps && $urandom_range(0, 99) < 37) begin
      start <= 0;
      @(negedge clk);
    end
    item <= w;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(w);
    @(negedge clk);
  endtask

  task automatic send_random(bit gaps);
    in_word_t w;
    logic signed [CRD_W-1:0] dx, dy;
    w = '0;
    w.first_start_x = rnd_crd(); w.first_start_y = rnd_crd();
    w.first_end_x = rnd_crd();   w.first_end_y = rnd_crd();
    w.second_start_x = rnd_crd(); w.second_start_y = rnd_crd();
    w.second_end_x = rnd_crd();  w.second_end_y = rnd_crd();
    case ($urandom_range(0, 9))
      0: begin
        // parallel or coincident: same direction vector
        dx = w.first_end_x - w.first_start_x;
        dy = w.first_end_y - w.first_start_y;
        if ($urandom_range(0, 1)) begin
          w.second_start_x = w.first_start_x +
                             $signed(CRD_W'($urandom_range(0, 2))) * dx;
          w.second_start_y = w.first_start_y +
                             $signed(CRD_W'($urandom_range(0, 2))) * dy;
        end
        w.second_end_x = w.second_start_x + dx;
        w.second_end_y = w.second_start_y + dy;
      end
      1: begin
        w.first_end_x = w.first_start_x;
        w.first_end_y = w.first_start_y;
      end
      2: begin
        w.second_start_x = CRD_W'($urandom_range(0, 6) - 3);
        w.second_start_y = CRD_W'($urandom_range(0, 6) - 3);
        w.second_end_x = CRD_W'($urandom_range(0, 6) - 3);
        w.second_end_y = CRD_W'($urandom_range(0, 6) - 3);
        w.first_start_x = CRD_W'($urandom_range(0, 6) - 3);
        w.first_end_y = CRD_W'($urandom_range(0, 6) - 3);
      end
      default: ;
    endcase
    send(w, gaps);
  endtask

  task automatic wait_drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    in_word_t w;
    sb = new();
    rst = 1;
    start = 0;
    item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // crossing at (1, 1), parallel, coincident, degenerate, extremes
    w = '0; w.first_end_x = 2; w.first_end_y = 2;
    w.second_start_y = 2; w.second_end_x = 2; send(w, 0);
    w = '0; w.first_end_x = 1; w.second_start_y = 1;
    w.second_end_x = 1; w.second_end_y = 1; send(w, 0);
    w = '0; w.first_end_x = 1; w.second_start_x = 3; w.second_end_x = 7; send(w, 0);
    w = '0; w.first_start_x = 5; w.first_end_x = 5; send(w, 0);
    w = '0; send(w, 0);
    w = '0; w.first_end_x = 3; w.first_end_y = 1;
    w.second_start_y = 1; w.second_end_x = 1; send(w, 0);
    w = '0; w.first_end_x = -3; w.first_end_y = 1;
    w.second_start_y = 1; w.second_end_x = 1; send(w, 0);
    w = '0; w.first_end_x = 8; w.first_end_y = 1;
    w.second_start_y = 1; w.second_end_x = 1; send(w, 0);
    w = '0; w.first_start_x = CMIN; w.first_start_y = CMIN;
    w.first_end_x = CMAX; w.first_end_y = CMAX - 1;
    w.second_start_x = CMIN; w.second_start_y = CMAX;
    w.second_end_x = CMAX; w.second_end_y = CMIN; send(w, 0);
    w = '0; w.first_start_x = CMIN; w.first_end_x = CMAX; w.first_end_y = 1;
    w.second_start_x = CMIN; w.second_start_y = CMAX;
    w.second_end_x = CMAX; w.second_end_y = CMAX - 1; send(w, 0);
    w = {8{CMAX}}; send(w, 0);
    w = {8{CMIN}}; send(w, 0);
    w = '1; w.first_end_x = 0; w.second_end_y = 0; send(w, 0);
    w = '0; w.first_start_x = CMAX; w.first_end_y = CMAX;
    w.second_start_x = CMIN; w.second_end_y = CMIN; send(w, 0);

    for (int i = 0; i < 400; i++) send_random(0);
    wait_drain();
    for (int i = 0; i < 1400; i++) begin
      send_random(1);
      if (i == 700) wait_drain();
    end

    wait_drain();
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_line_pair_intersection OK");
    else
      $display("tb_line_pair_intersection NOT OK");
    $finish;
  end
endmodule

[line_pair_intersection.f]
sv/lpi_pkg.sv
sv/lpi_div.sv
sv/line_pair_intersection.sv
tb/tb_line_pair_intersection.sv
